// ===== src/per_source_login_backoff_limiter_macros.svh =====
// assertion helpers for the checker file
`ifndef PER_SOURCE_LOGIN_BACKOFF_LIMITER_MACROS_SVH
`define PER_SOURCE_LOGIN_BACKOFF_LIMITER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PLBL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("plbl assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PLBL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("plbl assertion failed");

`endif

// ===== src/plbl_pkg.sv =====
package plbl_pkg;

	localparam int DEF_SLOTS = 8;

	localparam int SRC_W    = 32;
	localparam int TIME_W   = 32;
	localparam int FAIL_W   = 10;
	localparam int BASE_W   = 16;
	localparam int MAX_W    = 23;
	localparam int RETRY_W  = 22;
	localparam int CFG_W    = 32;
	localparam int CFG_IDXW = 2;

	localparam logic [FAIL_W-1:0] FAIL_CAP    = 10'd1000;
	localparam logic [4:0]        SHIFT_CAP   = 5'd16;
	localparam logic [MAX_W-1:0]  RETRY_MAX   = 23'd4194303;
	localparam logic [9:0]        MS_PER_SEC  = 10'd1000;
	localparam logic [9:0]        ROUND_UP    = 10'd999;

	// floor(x / 1000) == (x * DIV1000_MAGIC) >> DIV1000_SHIFT for any 32-bit x
	localparam logic [28:0] DIV1000_MAGIC = 29'd274877907;
	localparam int          DIV1000_SHIFT = 38;

	localparam logic [FAIL_W-1:0] RST_FREE_ATTEMPTS = 10'd3;
	localparam logic [BASE_W-1:0] RST_BASE_LOCK     = 16'd15;
	localparam logic [MAX_W-1:0]  RST_MAX_LOCK      = 23'd900;
	localparam logic [TIME_W-1:0] RST_DECAY_MS      = 32'd900000;

	typedef enum logic [CFG_IDXW-1:0] {
		REG_FREE_ATTEMPTS,
		REG_BASE_LOCK,
		REG_MAX_LOCK,
		REG_DECAY_MS
	} cfg_reg_t;

	typedef enum logic [1:0] {
		VERDICT_ACCEPT,
		VERDICT_FAIL,
		VERDICT_LOCKED,
		VERDICT_REFUSED
	} verdict_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SCAN_END,
		ST_EVAL,
		ST_SECS,
		ST_MUL,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic [SRC_W-1:0]  source;
		logic [FAIL_W-1:0] failures;
		logic [TIME_W-1:0] lock_until;
		logic [TIME_W-1:0] last_seen;
	} entry_t;

	typedef struct packed {
		logic load;
		logic rd;
		logic eval;
		logic secs;
		logic mul;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic scan_last;
	} dp_status_t;

	// zero means unlocked; otherwise locked while the deadline is still ahead
	function automatic logic is_locked(logic [TIME_W-1:0] lock_until, logic [TIME_W-1:0] now);
		logic [TIME_W-1:0] d;
		d = lock_until - now;
		return (lock_until != '0) && (d != '0) && !d[TIME_W-1];
	endfunction

endpackage

// ===== src/plbl_ram.sv =====
module plbl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/plbl_ctrl.sv =====
module plbl_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	output plbl_pkg::dp_cmd_t    cmd,
	input  plbl_pkg::dp_status_t status
);

	import plbl_pkg::*;

	ctrl_state_t state_q;
	ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.rd = 1'b1;
				if (status.scan_last) begin
					state_d = ST_SCAN_END;
				end
			end
			// last entry read is still in flight
			ST_SCAN_END: begin
				state_d = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = ST_SECS;
			end
			ST_SECS: begin
				cmd.secs = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				cmd.commit = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== src/plbl_dp.sv =====
module plbl_dp #(
	parameter int SLOTS = plbl_pkg::DEF_SLOTS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  plbl_pkg::dp_cmd_t                     cmd,
	output plbl_pkg::dp_status_t                  status,
	input  logic [plbl_pkg::SRC_W-1:0]            source_address,
	input  logic [plbl_pkg::TIME_W-1:0]           now_ms,
	input  logic                                  credentials_ok,
	input  logic                                  cfg_we,
	input  logic [plbl_pkg::CFG_IDXW-1:0]         cfg_index,
	input  logic [plbl_pkg::CFG_W-1:0]            cfg_data,
	output logic                                  done,
	output logic [1:0]                            verdict,
	output logic [plbl_pkg::FAIL_W-1:0]           attempt_count,
	output logic [plbl_pkg::RETRY_W-1:0]          retry_after_seconds,
	output logic [2:0]                            slot_index
);

	import plbl_pkg::*;

	localparam int AW      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ENTRY_W = $bits(entry_t);
	localparam int PROD_W  = TIME_W + 29;

	// configuration
	logic [FAIL_W-1:0] cfg_free_q;
	logic [BASE_W-1:0] cfg_base_q;
	logic [MAX_W-1:0]  cfg_max_q;
	logic [TIME_W-1:0] cfg_decay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_free_q  <= RST_FREE_ATTEMPTS;
			cfg_base_q  <= RST_BASE_LOCK;
			cfg_max_q   <= RST_MAX_LOCK;
			cfg_decay_q <= RST_DECAY_MS;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_FREE_ATTEMPTS: cfg_free_q  <= cfg_data[FAIL_W-1:0];
				REG_BASE_LOCK:     cfg_base_q  <= cfg_data[BASE_W-1:0];
				REG_MAX_LOCK:      cfg_max_q   <= cfg_data[MAX_W-1:0];
				REG_DECAY_MS:      cfg_decay_q <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// attempt latched at the start transfer
	logic [SRC_W-1:0]  src_q;
	logic [TIME_W-1:0] now_q;
	logic              ok_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			src_q <= source_address;
			now_q <= now_ms;
			ok_q  <= credentials_ok;
		end
	end

	// table: valid bits in flops, entry payload in ram
	logic [SLOTS-1:0]   valid_q;
	logic [AW-1:0]      addr_q;
	logic               rd_valid_s1;
	logic [AW-1:0]      rd_idx_s1;
	logic [ENTRY_W-1:0] rd_word;
	entry_t             rd_entry;
	entry_t             wr_entry;
	logic [AW-1:0]      slot_q;

	plbl_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SLOTS),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (slot_q),
		.wdata (wr_entry),
		.re    (cmd.rd),
		.raddr (addr_q),
		.rdata (rd_word)
	);

	assign rd_entry         = entry_t'(rd_word);
	assign status.scan_last = (addr_q == AW'(SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q      <= '0;
			rd_valid_s1 <= 1'b0;
			valid_q     <= '0;
		end else begin
			rd_valid_s1 <= cmd.rd;
			if (cmd.load) begin
				addr_q <= '0;
			end else if (cmd.rd) begin
				addr_q <= addr_q + 1'b1;
			end
			if (cmd.commit) begin
				valid_q[slot_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= addr_q;
	end

	// scan: first hit, first free, longest silent unlocked, earliest lock expiry
	logic              hit_q, free_q, lru_q;
	logic [AW-1:0]     hit_idx_q, free_idx_q, lru_idx_q, el_idx_q;
	logic [FAIL_W-1:0] hit_fail_q;
	logic [TIME_W-1:0] hit_lock_q, hit_last_q, lru_age_q, el_lock_q;

	logic              rd_used, rd_match, rd_locked;
	logic [TIME_W-1:0] rd_age, el_diff;
	logic              hit_upd, free_upd, lru_upd, el_upd;

	always_comb begin
		rd_used   = valid_q[rd_idx_s1];
		rd_match  = rd_used && (rd_entry.source == src_q);
		rd_locked = is_locked(rd_entry.lock_until, now_q);
		rd_age    = now_q - rd_entry.last_seen;
		el_diff   = rd_entry.lock_until - el_lock_q;
		hit_upd   = rd_valid_s1 && rd_match && !hit_q;
		free_upd  = rd_valid_s1 && !rd_used && !free_q;
		lru_upd   = rd_valid_s1 && rd_used && !rd_locked && (!lru_q || (rd_age > lru_age_q));
		el_upd    = rd_valid_s1 && rd_used && ((rd_idx_s1 == '0) || el_diff[TIME_W-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else if (cmd.load) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else begin
			if (hit_upd) hit_q <= 1'b1;
			if (free_upd) free_q <= 1'b1;
			if (lru_upd) lru_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_upd) begin
			hit_idx_q  <= rd_idx_s1;
			hit_fail_q <= rd_entry.failures;
			hit_lock_q <= rd_entry.lock_until;
			hit_last_q <= rd_entry.last_seen;
		end
		if (free_upd) begin
			free_idx_q <= rd_idx_s1;
		end
		if (lru_upd) begin
			lru_idx_q <= rd_idx_s1;
			lru_age_q <= rd_age;
		end
		if (el_upd) begin
			el_idx_q  <= rd_idx_s1;
			el_lock_q <= rd_entry.lock_until;
		end
	end

	// evaluate the attempt against the chosen slot
	logic              hit_locked, decay_clr, cur_locked, over_quota;
	logic [FAIL_W-1:0] cur_fail, inc_fail, over_raw;
	logic [TIME_W-1:0] cur_lock;
	logic [AW-1:0]     sel_idx;
	logic [4:0]        over_cap;
	verdict_t          verdict_d;
	logic [FAIL_W-1:0] fail_d;

	always_comb begin
		if (hit_q) begin
			sel_idx = hit_idx_q;
		end else if (free_q) begin
			sel_idx = free_idx_q;
		end else if (lru_q) begin
			sel_idx = lru_idx_q;
		end else begin
			sel_idx = el_idx_q;
		end
		hit_locked = is_locked(hit_lock_q, now_q);
		decay_clr  = !hit_locked && ((now_q - hit_last_q) >= cfg_decay_q);
		cur_fail   = (hit_q && !decay_clr) ? hit_fail_q : '0;
		cur_lock   = (hit_q && !decay_clr) ? hit_lock_q : '0;
		cur_locked = hit_q && hit_locked;
		inc_fail   = (cur_fail < FAIL_CAP) ? cur_fail + 1'b1 : cur_fail;
		over_quota = inc_fail > cfg_free_q;
		over_raw   = inc_fail - cfg_free_q - 1'b1;
		over_cap   = (over_raw > FAIL_W'(SHIFT_CAP)) ? SHIFT_CAP : over_raw[4:0];
		if (cur_locked) begin
			verdict_d = VERDICT_REFUSED;
			fail_d    = cur_fail;
		end else if (ok_q) begin
			verdict_d = VERDICT_ACCEPT;
			fail_d    = '0;
		end else if (over_quota) begin
			verdict_d = VERDICT_LOCKED;
			fail_d    = inc_fail;
		end else begin
			verdict_d = VERDICT_FAIL;
			fail_d    = inc_fail;
		end
	end

	verdict_t          verdict_q;
	logic [FAIL_W-1:0] fail_q;
	logic [TIME_W-1:0] lock_q, dist_q, ms_q;
	logic [4:0]        over_q;
	logic [MAX_W-1:0]  secs_q;
	logic [PROD_W-1:0] quot_prod_q;

	logic [TIME_W-1:0] shifted, rnd;
	logic [PROD_W-1:0] quot_prod_d;
	logic [MAX_W+9:0]  ms_full;

	always_comb begin
		shifted     = {{(TIME_W - BASE_W){1'b0}}, cfg_base_q} << over_q;
		rnd         = dist_q + TIME_W'(ROUND_UP);
		quot_prod_d = {29'b0, rnd} * {{TIME_W{1'b0}}, DIV1000_MAGIC};
		ms_full     = {10'b0, secs_q} * {{MAX_W{1'b0}}, MS_PER_SEC};
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			slot_q    <= sel_idx;
			verdict_q <= verdict_d;
			fail_q    <= fail_d;
			lock_q    <= ok_q && !cur_locked ? '0 : cur_lock;
			over_q    <= over_cap;
			dist_q    <= hit_lock_q - now_q;
		end
		if (cmd.secs) begin
			secs_q      <= (shifted > TIME_W'(cfg_max_q)) ? cfg_max_q : shifted[MAX_W-1:0];
			quot_prod_q <= quot_prod_d;
		end
		if (cmd.mul) begin
			ms_q <= ms_full[TIME_W-1:0];
		end
	end

	// write back and present the result
	logic [RETRY_W-1:0] retry_d;

	always_comb begin
		wr_entry.source     = src_q;
		wr_entry.failures   = fail_q;
		wr_entry.lock_until = (verdict_q == VERDICT_LOCKED) ? now_q + ms_q : lock_q;
		wr_entry.last_seen  = now_q;
		case (verdict_q)
			VERDICT_REFUSED: retry_d = quot_prod_q[DIV1000_SHIFT +: RETRY_W];
			VERDICT_LOCKED:  retry_d = (secs_q > RETRY_MAX) ? RETRY_MAX[RETRY_W-1:0]
			                                                : secs_q[RETRY_W-1:0];
			default:         retry_d = '0;
		endcase
	end

	logic               done_q;
	verdict_t           verdict_out_q;
	logic [FAIL_W-1:0]  count_out_q;
	logic [RETRY_W-1:0] retry_out_q;
	logic [AW-1:0]      slot_out_q;
	logic [AW+2:0]      slot_wide;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_out_q <= verdict_q;
			count_out_q   <= fail_q;
			retry_out_q   <= retry_d;
			slot_out_q    <= slot_q;
		end
	end

	assign slot_wide           = {3'b000, slot_out_q};
	assign done                = done_q;
	assign verdict             = verdict_out_q;
	assign attempt_count       = count_out_q;
	assign retry_after_seconds = retry_out_q;
	assign slot_index          = slot_wide[2:0];

endmodule

// ===== src/per_source_login_backoff_limiter.sv =====
// the result transfer follows the start transfer after the slot scan and the eval, secs, mul and commit states
// one attempt at a time: start is taken only while idle, and is taken again in the done cycle
// the slot scan reads one table entry a cycle from the single ram read port
// done is a one-cycle strobe; the receiver cannot stall it
// reset: controller idle, all slots free, registers at defaults; no clearing pass
module per_source_login_backoff_limiter #(
	parameter int SLOTS = plbl_pkg::DEF_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [plbl_pkg::SRC_W-1:0]    source_address,
	input  logic [plbl_pkg::TIME_W-1:0]   now_ms,
	input  logic                          credentials_ok,
	output logic                          done,
	output logic [1:0]                    verdict,
	output logic [plbl_pkg::FAIL_W-1:0]   attempt_count,
	output logic [plbl_pkg::RETRY_W-1:0]  retry_after_seconds,
	output logic [2:0]                    slot_index,
	input  logic                          cfg_we,
	input  logic [plbl_pkg::CFG_IDXW-1:0] cfg_index,
	input  logic [plbl_pkg::CFG_W-1:0]    cfg_data
);

	import plbl_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	plbl_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	plbl_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.status              (status),
		.source_address      (source_address),
		.now_ms              (now_ms),
		.credentials_ok      (credentials_ok),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.done                (done),
		.verdict             (verdict),
		.attempt_count       (attempt_count),
		.retry_after_seconds (retry_after_seconds),
		.slot_index          (slot_index)
	);

endmodule

// ===== src/plbl_checker.sv =====
`include "per_source_login_backoff_limiter_macros.svh"

module plbl_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          start,
	input logic                          busy,
	input logic                          done,
	input logic [1:0]                    verdict,
	input logic [plbl_pkg::FAIL_W-1:0]   attempt_count,
	input logic [plbl_pkg::RETRY_W-1:0]  retry_after_seconds
);

	import plbl_pkg::*;

	// the result transfer lands while the block is free for the next attempt
	`PLBL_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy)

	// an accepted attempt keeps the block busy and cannot finish at once
	`PLBL_ASSERT_NXT(a_start_busy, clk, arst_n, start && !busy, busy && !done)

	// no retry time unless the source is or becomes locked
	`PLBL_ASSERT_IMP(a_retry_zero, clk, arst_n,
		done && (verdict == VERDICT_ACCEPT || verdict == VERDICT_FAIL),
		retry_after_seconds == '0)

	// refused attempts always carry a retry time and a success clears the count
	`PLBL_ASSERT_IMP(a_refuse_retry, clk, arst_n,
		done && verdict == VERDICT_REFUSED, retry_after_seconds != '0)
	`PLBL_ASSERT_IMP(a_accept_clear, clk, arst_n,
		done && verdict == VERDICT_ACCEPT, attempt_count == '0)

endmodule

bind per_source_login_backoff_limiter plbl_checker u_plbl_checker (.*);
